>>> rtl/rrfe_pkg.sv
// ----------------------------------------------------------------------------
// rrfe_pkg
// Shared types, constants and the CRC-8 byte update for the register request
// frame encoder.
// ----------------------------------------------------------------------------
package rrfe_pkg;

   localparam int BYTE_W       = 8;
   localparam int DATA_W       = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = 1;
   localparam int QUEUE_CNT_W  = 2;
   localparam int BYTE_IDX_W   = 3;

   localparam logic [BYTE_W-1:0] CRC_TOP_BIT = 8'h80;

   // Position of each byte inside a frame.
   localparam logic [BYTE_IDX_W-1:0] POS_SYNC     = 3'd0;
   localparam logic [BYTE_IDX_W-1:0] POS_CMD      = 3'd1;
   localparam logic [BYTE_IDX_W-1:0] POS_ADDR     = 3'd2;
   localparam logic [BYTE_IDX_W-1:0] POS_DATA_HI  = 3'd3;
   localparam logic [BYTE_IDX_W-1:0] POS_DATA_LO  = 3'd4;
   localparam logic [BYTE_IDX_W-1:0] POS_CRC_READ  = 3'd3;
   localparam logic [BYTE_IDX_W-1:0] POS_CRC_WRITE = 3'd5;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_BYTE  = 3'd0,
      CSR_WRITE_FLAG = 3'd1,
      CSR_READ_FLAG  = 3'd2,
      CSR_NODE_MASK  = 3'd3,
      CSR_CRC_POLY   = 3'd4,
      CSR_CRC_INIT   = 3'd5,
      CSR_CRC_XOROUT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_byte;
      logic [BYTE_W-1:0] write_flag;
      logic [BYTE_W-1:0] read_flag;
      logic [BYTE_W-1:0] node_mask;
      logic [BYTE_W-1:0] crc_poly;
      logic [BYTE_W-1:0] crc_init;
      logic [BYTE_W-1:0] crc_xorout;
   } cfg_type;

   // One classified request, ready for serializing.
   typedef struct packed {
      logic              is_read;
      logic [BYTE_W-1:0] sync_byte;
      logic [BYTE_W-1:0] cmd_byte;
      logic [BYTE_W-1:0] addr_byte;
      logic [DATA_W-1:0] data;
   } frame_entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   // MSB-first CRC-8 update over one byte.
   function automatic logic [BYTE_W-1:0] crc_feed(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data,
                                                  input logic [BYTE_W-1:0] poly);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if ((c & CRC_TOP_BIT) != '0) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ poly;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/rrfe_front.sv
// ----------------------------------------------------------------------------
// rrfe_front
// Accepts a request and classifies it: builds the command byte from the
// read or write flag and the masked node id, and hands the entry to the queue.
// ----------------------------------------------------------------------------
module rrfe_front (
   input  logic                          start,
   input  logic                          queue_full,
   input  logic                          req_action,
   input  logic [rrfe_pkg::BYTE_W-1:0]   req_node_id,
   input  logic [rrfe_pkg::BYTE_W-1:0]   req_reg_addr,
   input  logic [rrfe_pkg::DATA_W-1:0]   req_write_data,
   input  rrfe_pkg::cfg_type             cfg,
   output logic                          busy,
   output logic                          push,
   output rrfe_pkg::frame_entry_type     entry
);

   logic                        is_read;
   logic [rrfe_pkg::BYTE_W-1:0] flag;

   always_comb begin
      is_read = (req_action == rrfe_pkg::ACTION_READ);
      flag    = is_read ? cfg.read_flag : cfg.write_flag;

      entry.is_read   = is_read;
      entry.sync_byte = cfg.sync_byte;
      entry.cmd_byte  = flag | (req_node_id & cfg.node_mask);
      entry.addr_byte = req_reg_addr;
      entry.data      = req_write_data;
   end

   assign busy = queue_full;
   assign push = start && !queue_full;

endmodule

>>> rtl/rrfe_queue.sv
// ----------------------------------------------------------------------------
// rrfe_queue
// Two-entry queue of classified requests between the front and the
// serializer.
// ----------------------------------------------------------------------------
module rrfe_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  rrfe_pkg::queue_ctrl_type    ctrl,
   input  rrfe_pkg::frame_entry_type   wr_entry,
   output rrfe_pkg::frame_entry_type   rd_entry,
   output rrfe_pkg::queue_status_type  status
);

   rrfe_pkg::frame_entry_type entries_ff [rrfe_pkg::QUEUE_DEPTH];

   logic [rrfe_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rrfe_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rrfe_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                             do_push, do_pop;

   always_comb begin
      status.valid = (count_ff != '0);
      status.full  = (count_ff == rrfe_pkg::QUEUE_CNT_W'(rrfe_pkg::QUEUE_DEPTH));
      do_push      = ctrl.push && !status.full;
      do_pop       = ctrl.pop && status.valid;

      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      rd_entry = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

>>> rtl/rrfe_back.sv
// ----------------------------------------------------------------------------
// rrfe_back
// Serializer: sends one frame byte per cycle and folds each byte into the
// running CRC, then sends the CRC byte that closes the frame.
// ----------------------------------------------------------------------------
module rrfe_back (
   input  logic                          clock,
   input  logic                          reset,
   input  rrfe_pkg::cfg_type             cfg,
   input  logic                          queue_valid,
   input  rrfe_pkg::frame_entry_type     queue_entry,
   output logic                          pop,
   output logic                          rsp_strobe,
   output logic [rrfe_pkg::BYTE_W-1:0]   rsp_frame_byte,
   output logic                          rsp_last_byte
);

   logic                              active_ff, active_in;
   logic [rrfe_pkg::BYTE_IDX_W-1:0]   idx_ff, idx_in;
   logic [rrfe_pkg::BYTE_W-1:0]       crc_ff, crc_in;
   rrfe_pkg::frame_entry_type         entry_ff, entry_in;
   logic                              strobe_ff, strobe_in;
   logic [rrfe_pkg::BYTE_W-1:0]       byte_ff, byte_in;
   logic                              last_ff, last_in;

   logic [rrfe_pkg::BYTE_IDX_W-1:0]   last_idx;
   logic                              at_last;
   logic [rrfe_pkg::BYTE_W-1:0]       cur_byte;
   logic [rrfe_pkg::BYTE_W-1:0]       crc_base;

   always_comb begin
      last_idx = entry_ff.is_read ? rrfe_pkg::POS_CRC_READ : rrfe_pkg::POS_CRC_WRITE;
      at_last  = active_ff && (idx_ff == last_idx);
      pop      = queue_valid && (!active_ff || at_last);

      case (idx_ff)
         rrfe_pkg::POS_SYNC:    cur_byte = entry_ff.sync_byte;
         rrfe_pkg::POS_CMD:     cur_byte = entry_ff.cmd_byte;
         rrfe_pkg::POS_ADDR:    cur_byte = entry_ff.addr_byte;
         rrfe_pkg::POS_DATA_HI: cur_byte = entry_ff.data[rrfe_pkg::DATA_W-1:rrfe_pkg::BYTE_W];
         rrfe_pkg::POS_DATA_LO: cur_byte = entry_ff.data[rrfe_pkg::BYTE_W-1:0];
         default:               cur_byte = '0;
      endcase

      // Every frame restarts the CRC from the init value.
      crc_base = (idx_ff == rrfe_pkg::POS_SYNC) ? cfg.crc_init : crc_ff;
      crc_in   = rrfe_pkg::crc_feed(crc_base, cur_byte, cfg.crc_poly);

      strobe_in = active_ff;
      byte_in   = at_last ? (crc_ff ^ cfg.crc_xorout) : cur_byte;
      last_in   = at_last;

      if (pop) begin
         active_in = 1'b1;
         idx_in    = rrfe_pkg::POS_SYNC;
         entry_in  = queue_entry;
      end else begin
         active_in = active_ff && !at_last;
         idx_in    = idx_ff + 1'b1;
         entry_in  = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      crc_ff   <= crc_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_last_byte  = last_ff;

endmodule

>>> rtl/register_request_frame_encoder.sv
// ----------------------------------------------------------------------------
// register_request_frame_encoder
// Turns register read and write requests into framed byte streams that end
// in a CRC-8 byte.
//
//   channel   handshake             payload
//   request   start / busy          req_action, req_node_id, req_reg_addr,
//                                   req_write_data
//   response  rsp_strobe            rsp_frame_byte, rsp_last_byte
//   csr       csr_valid / csr_ready csr_index, csr_data
//
// A write frame has six bytes and a read frame four; the serializer sends one
// byte per cycle, and frames follow each other with no gap while a request
// waits in the queue. busy is high while the two-entry request queue is full.
// Reset restores the default register values and empties the queue. The
// receiver takes every byte in its strobe cycle.
// ----------------------------------------------------------------------------
module register_request_frame_encoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic [rrfe_pkg::BYTE_W-1:0]         req_node_id,
   input  logic [rrfe_pkg::BYTE_W-1:0]         req_reg_addr,
   input  logic [rrfe_pkg::DATA_W-1:0]         req_write_data,
   output logic                                rsp_strobe,
   output logic [rrfe_pkg::BYTE_W-1:0]         rsp_frame_byte,
   output logic                                rsp_last_byte,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rrfe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rrfe_pkg::BYTE_W-1:0]         csr_data
);

   rrfe_pkg::cfg_type           cfg_ff, cfg_in;
   rrfe_pkg::frame_entry_type   front_entry;
   rrfe_pkg::frame_entry_type   head_entry;
   rrfe_pkg::queue_ctrl_type    q_ctrl;
   rrfe_pkg::queue_status_type  q_status;
   logic                        push;
   logic                        pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (rrfe_pkg::csr_index_type'(csr_index))
            rrfe_pkg::CSR_SYNC_BYTE:  cfg_in.sync_byte  = csr_data;
            rrfe_pkg::CSR_WRITE_FLAG: cfg_in.write_flag = csr_data;
            rrfe_pkg::CSR_READ_FLAG:  cfg_in.read_flag  = csr_data;
            rrfe_pkg::CSR_NODE_MASK:  cfg_in.node_mask  = csr_data;
            rrfe_pkg::CSR_CRC_POLY:   cfg_in.crc_poly   = csr_data;
            rrfe_pkg::CSR_CRC_INIT:   cfg_in.crc_init   = csr_data;
            rrfe_pkg::CSR_CRC_XOROUT: cfg_in.crc_xorout = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte  <= 8'h1E;
         cfg_ff.write_flag <= 8'h80;
         cfg_ff.read_flag  <= 8'h00;
         cfg_ff.node_mask  <= 8'h3F;
         cfg_ff.crc_poly   <= 8'h1D;
         cfg_ff.crc_init   <= 8'hFF;
         cfg_ff.crc_xorout <= 8'hFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rrfe_front u_front (
      .start          (start),
      .queue_full     (q_status.full),
      .req_action     (req_action),
      .req_node_id    (req_node_id),
      .req_reg_addr   (req_reg_addr),
      .req_write_data (req_write_data),
      .cfg            (cfg_ff),
      .busy           (busy),
      .push           (push),
      .entry          (front_entry)
   );

   assign q_ctrl.push = push;
   assign q_ctrl.pop  = pop;

   rrfe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (q_ctrl),
      .wr_entry (front_entry),
      .rd_entry (head_entry),
      .status   (q_status)
   );

   rrfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .queue_valid    (q_status.valid),
      .queue_entry    (head_entry),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for register_request_frame_encoder. A short table of
// directed requests and register writes runs first, then randomized requests
// under random register settings. Every byte the block emits is compared with
// a frame built from the bench's own copy of the registers and its own CRC-8.
// ----------------------------------------------------------------------------
module tb;

   localparam int STALL_LIMIT = 2000;
   localparam int RAND_PHASES = 8;
   localparam int RAND_ITEMS_PER_PHASE = 57;
   localparam logic [rrfe_pkg::CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;

   localparam rrfe_pkg::cfg_type CFG_AT_RESET = '{sync_byte: 8'h1E, write_flag: 8'h80,
                                                  read_flag: 8'h00, node_mask: 8'h3F,
                                                  crc_poly: 8'h1D, crc_init: 8'hFF,
                                                  crc_xorout: 8'hFF};

   typedef struct packed {
      logic [rrfe_pkg::BYTE_W-1:0] frame_byte;
      logic                        last_byte;
   } rsp_word_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic                           action;
      logic [rrfe_pkg::BYTE_W-1:0]    node;
      logic [rrfe_pkg::BYTE_W-1:0]    addr;
      logic [rrfe_pkg::DATA_W-1:0]    data;
      logic                           has_cmd;
      logic [rrfe_pkg::BYTE_W-1:0]    cmd;
      logic                           has_crc;
      logic [rrfe_pkg::BYTE_W-1:0]    crc;
      logic [5:0]                     gap;
      logic [rrfe_pkg::CSR_IDX_W-1:0] csr_idx;
      logic [rrfe_pkg::BYTE_W-1:0]    csr_val;
   } stim_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic                           req_action = rrfe_pkg::ACTION_WRITE;
   logic [rrfe_pkg::BYTE_W-1:0]    req_node_id = '0;
   logic [rrfe_pkg::BYTE_W-1:0]    req_reg_addr = '0;
   logic [rrfe_pkg::DATA_W-1:0]    req_write_data = '0;
   logic                           rsp_strobe;
   logic [rrfe_pkg::BYTE_W-1:0]    rsp_frame_byte;
   logic                           rsp_last_byte;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [rrfe_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rrfe_pkg::BYTE_W-1:0]    csr_data = '0;

   register_request_frame_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_node_id    (req_node_id),
      .req_reg_addr   (req_reg_addr),
      .req_write_data (req_write_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rsp_word_type      frame_words[$];
   rrfe_pkg::cfg_type shadow_cfg;
   stim_row_type      stim_table[$];
   bit                no_idle = 1'b0;
   int                failures = 0;
   int                words_checked = 0;
   int                write_frames = 0;
   int                read_frames = 0;
   int                csr_writes = 0;
   int                idle_cycles = 0;

   // Values typed into the directed table override the predicted ones.
   logic                        fixed_cmd_en = 1'b0;
   logic [rrfe_pkg::BYTE_W-1:0] fixed_cmd = '0;
   logic                        fixed_crc_en = 1'b0;
   logic [rrfe_pkg::BYTE_W-1:0] fixed_crc = '0;

   function automatic logic [rrfe_pkg::BYTE_W-1:0] crc8_step(
         input logic [rrfe_pkg::BYTE_W-1:0] crc,
         input logic [rrfe_pkg::BYTE_W-1:0] b,
         input logic [rrfe_pkg::BYTE_W-1:0] poly);
      logic [rrfe_pkg::BYTE_W-1:0] r;
      r = crc ^ b;
      for (int k = 0; k < rrfe_pkg::BYTE_W; k++) begin
         r = r[rrfe_pkg::BYTE_W-1] ? ((r << 1) ^ poly) : (r << 1);
      end
      return r;
   endfunction

   // Builds the expected frame for one accepted request and queues its words.
   function automatic void predict_frame(input rrfe_pkg::cfg_type c, input logic action,
                                         input logic [rrfe_pkg::BYTE_W-1:0] node,
                                         input logic [rrfe_pkg::BYTE_W-1:0] addr,
                                         input logic [rrfe_pkg::DATA_W-1:0] data);
      logic [rrfe_pkg::BYTE_W-1:0] body [0:4];
      logic [rrfe_pkg::BYTE_W-1:0] crc;
      rsp_word_type                w;
      int                          n;
      body[0] = c.sync_byte;
      body[1] = ((action == rrfe_pkg::ACTION_READ) ? c.read_flag : c.write_flag)
                | (node & c.node_mask);
      if (fixed_cmd_en) body[1] = fixed_cmd;
      body[2] = addr;
      body[3] = data[rrfe_pkg::DATA_W-1:rrfe_pkg::BYTE_W];
      body[4] = data[rrfe_pkg::BYTE_W-1:0];
      n = (action == rrfe_pkg::ACTION_READ) ? 3 : 5;
      crc = c.crc_init;
      for (int i = 0; i < n; i++) begin
         crc = crc8_step(crc, body[i], c.crc_poly);
         w.frame_byte = body[i];
         w.last_byte = 1'b0;
         frame_words.push_back(w);
      end
      w.frame_byte = fixed_crc_en ? fixed_crc : (crc ^ c.crc_xorout);
      w.last_byte = 1'b1;
      frame_words.push_back(w);
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
   endfunction

   function automatic stim_row_type plain_req(input logic action,
                                              input logic [rrfe_pkg::BYTE_W-1:0] node,
                                              input logic [rrfe_pkg::BYTE_W-1:0] addr,
                                              input logic [rrfe_pkg::DATA_W-1:0] data,
                                              input int gap);
      stim_row_type r;
      r = '0;
      r.kind = ROW_REQ;
      r.action = action;
      r.node = node;
      r.addr = addr;
      r.data = data;
      r.gap = 6'(gap);
      return r;
   endfunction

   function automatic stim_row_type typed_req(input logic action,
                                              input logic [rrfe_pkg::BYTE_W-1:0] node,
                                              input logic [rrfe_pkg::BYTE_W-1:0] addr,
                                              input logic [rrfe_pkg::DATA_W-1:0] data,
                                              input logic [rrfe_pkg::BYTE_W-1:0] cmd,
                                              input logic has_crc,
                                              input logic [rrfe_pkg::BYTE_W-1:0] crc);
      stim_row_type r;
      r = plain_req(action, node, addr, data, 1);
      r.has_cmd = 1'b1;
      r.cmd = cmd;
      r.has_crc = has_crc;
      r.crc = crc;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [rrfe_pkg::CSR_IDX_W-1:0] idx,
                                            input logic [rrfe_pkg::BYTE_W-1:0] val);
      stim_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.csr_idx = idx;
      r.csr_val = val;
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [rrfe_pkg::BYTE_W-1:0] pick_reg_value();
      case ($urandom_range(0, 4))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic issue_request(input logic action, input logic [rrfe_pkg::BYTE_W-1:0] node,
                                input logic [rrfe_pkg::BYTE_W-1:0] addr,
                                input logic [rrfe_pkg::DATA_W-1:0] data,
                                input logic has_cmd, input logic [rrfe_pkg::BYTE_W-1:0] cmd,
                                input logic has_crc, input logic [rrfe_pkg::BYTE_W-1:0] crc,
                                input int gap);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      fixed_cmd_en = has_cmd;
      fixed_cmd = cmd;
      fixed_crc_en = has_crc;
      fixed_crc = crc;
      start <= 1'b1;
      req_action <= action;
      req_node_id <= node;
      req_reg_addr <= addr;
      req_write_data <= data;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_csr(input logic [rrfe_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rrfe_pkg::BYTE_W-1:0] val);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) repeat (gap) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_setting(input rrfe_pkg::cfg_type c);
      write_csr(rrfe_pkg::CSR_SYNC_BYTE, c.sync_byte);
      write_csr(rrfe_pkg::CSR_WRITE_FLAG, c.write_flag);
      write_csr(rrfe_pkg::CSR_READ_FLAG, c.read_flag);
      write_csr(rrfe_pkg::CSR_NODE_MASK, c.node_mask);
      write_csr(rrfe_pkg::CSR_CRC_POLY, c.crc_poly);
      write_csr(rrfe_pkg::CSR_CRC_INIT, c.crc_init);
      write_csr(rrfe_pkg::CSR_CRC_XOROUT, c.crc_xorout);
   endtask

   // Holds the request side off until every expected word has come out.
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (frame_words.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : monitor
      logic         progress;
      rsp_word_type want;
      if (reset) begin
         shadow_cfg = CFG_AT_RESET;
         idle_cycles = 0;
      end else begin
         progress = 1'b0;
         if (rsp_strobe) begin
            progress = 1'b1;
            if (frame_words.size() == 0) begin
               note_failure($sformatf("unexpected word %02h last %0b",
                                      rsp_frame_byte, rsp_last_byte));
            end else begin
               want = frame_words.pop_front();
               words_checked++;
               if (rsp_frame_byte !== want.frame_byte || rsp_last_byte !== want.last_byte) begin
                  note_failure($sformatf(
                     "word mismatch: expected %02h last %0b, got %02h last %0b",
                     want.frame_byte, want.last_byte, rsp_frame_byte, rsp_last_byte));
               end
            end
         end
         if (start && !busy) begin
            progress = 1'b1;
            predict_frame(shadow_cfg, req_action, req_node_id, req_reg_addr, req_write_data);
            if (req_action == rrfe_pkg::ACTION_READ) read_frames++;
            else write_frames++;
         end
         if (csr_valid && csr_ready) begin
            progress = 1'b1;
            csr_writes++;
            case (csr_index)
               rrfe_pkg::CSR_SYNC_BYTE:  shadow_cfg.sync_byte = csr_data;
               rrfe_pkg::CSR_WRITE_FLAG: shadow_cfg.write_flag = csr_data;
               rrfe_pkg::CSR_READ_FLAG:  shadow_cfg.read_flag = csr_data;
               rrfe_pkg::CSR_NODE_MASK:  shadow_cfg.node_mask = csr_data;
               rrfe_pkg::CSR_CRC_POLY:   shadow_cfg.crc_poly = csr_data;
               rrfe_pkg::CSR_CRC_INIT:   shadow_cfg.crc_init = csr_data;
               rrfe_pkg::CSR_CRC_XOROUT: shadow_cfg.crc_xorout = csr_data;
               default: ;
            endcase
         end
         if (progress) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   initial begin : stimulus
      stim_row_type      row;
      rrfe_pkg::cfg_type next_cfg;
      int                settings_used;

      // Reset values: only the command byte is obvious without a CRC table.
      stim_table.push_back(typed_req(rrfe_pkg::ACTION_WRITE, 8'hFF, 8'h00, 16'hFFFF, 8'hBF,
                                     1'b0, 8'h00));
      stim_table.push_back(typed_req(rrfe_pkg::ACTION_READ,  8'h00, 8'hFF, 16'hFFFF, 8'h00,
                                     1'b0, 8'h00));
      stim_table.push_back(typed_req(rrfe_pkg::ACTION_WRITE, 8'h40, 8'hA5, 16'h0000, 8'h80,
                                     1'b0, 8'h00));
      stim_table.push_back(typed_req(rrfe_pkg::ACTION_READ,  8'h3F, 8'h5A, 16'h1234, 8'h3F,
                                     1'b0, 8'h00));
      stim_table.push_back(typed_req(rrfe_pkg::ACTION_WRITE, 8'hC3, 8'h7F, 16'h8001, 8'h83,
                                     1'b0, 8'h00));
      // A zero polynomial shifts the register empty, so the CRC word equals xorout.
      stim_table.push_back(csr_row(rrfe_pkg::CSR_CRC_POLY, 8'h00));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_CRC_XOROUT, 8'h00));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_NODE_MASK, 8'h00));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_WRITE_FLAG, 8'hFF));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_READ_FLAG, 8'hFF));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_SYNC_BYTE, 8'hFF));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_CRC_INIT, 8'h00));
      // Writes to the unused index must leave every register alone.
      stim_table.push_back(csr_row(CSR_UNUSED_IDX, 8'hAA));
      stim_table.push_back(typed_req(rrfe_pkg::ACTION_WRITE, 8'hFF, 8'h00, 16'hFFFF, 8'hFF,
                                     1'b1, 8'h00));
      stim_table.push_back(typed_req(rrfe_pkg::ACTION_READ,  8'hAA, 8'h55, 16'h0000, 8'hFF,
                                     1'b1, 8'h00));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_CRC_XOROUT, 8'hFF));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_WRITE_FLAG, 8'h00));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_READ_FLAG, 8'h00));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_NODE_MASK, 8'hFF));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_SYNC_BYTE, 8'h00));
      stim_table.push_back(typed_req(rrfe_pkg::ACTION_WRITE, 8'h00, 8'h00, 16'h0000, 8'h00,
                                     1'b1, 8'hFF));
      stim_table.push_back(typed_req(rrfe_pkg::ACTION_READ,  8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
                                     1'b1, 8'hFF));
      stim_table.push_back(typed_req(rrfe_pkg::ACTION_WRITE, 8'h5A, 8'h3C, 16'hA55A, 8'h5A,
                                     1'b1, 8'hFF));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_CRC_POLY, 8'hFF));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_CRC_INIT, 8'hFF));
      // Back-to-back requests fill the request queue.
      stim_table.push_back(plain_req(rrfe_pkg::ACTION_WRITE, 8'h12, 8'h34, 16'h5678, 0));
      stim_table.push_back(plain_req(rrfe_pkg::ACTION_READ,  8'h9A, 8'hBC, 16'hDEF0, 0));
      stim_table.push_back(plain_req(rrfe_pkg::ACTION_WRITE, 8'hFF, 8'hFF, 16'hFFFF, 0));
      stim_table.push_back(plain_req(rrfe_pkg::ACTION_READ,  8'h00, 8'h00, 16'h0000, 0));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_SYNC_BYTE, CFG_AT_RESET.sync_byte));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_WRITE_FLAG, CFG_AT_RESET.write_flag));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_READ_FLAG, CFG_AT_RESET.read_flag));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_NODE_MASK, CFG_AT_RESET.node_mask));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_CRC_POLY, CFG_AT_RESET.crc_poly));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_CRC_INIT, CFG_AT_RESET.crc_init));
      stim_table.push_back(csr_row(rrfe_pkg::CSR_CRC_XOROUT, CFG_AT_RESET.crc_xorout));
      stim_table.push_back(plain_req(rrfe_pkg::ACTION_WRITE, 8'h01, 8'h10, 16'h0102, 0));
      stim_table.push_back(plain_req(rrfe_pkg::ACTION_READ,  8'h02, 8'h20, 16'hFFFF, 0));
      stim_table.push_back(plain_req(rrfe_pkg::ACTION_WRITE, 8'h80, 8'hFE, 16'h00FF, 0));
      stim_table.push_back(plain_req(rrfe_pkg::ACTION_READ,  8'h7F, 8'h01, 16'h0000, 0));
      settings_used = 5;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < stim_table.size(); i++) begin
         row = stim_table[i];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            write_csr(row.csr_idx, row.csr_val);
         end else begin
            issue_request(row.action, row.node, row.addr, row.data,
                          row.has_cmd, row.cmd, row.has_crc, row.crc, row.gap);
         end
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         wait_idle();
         next_cfg.sync_byte = pick_reg_value();
         next_cfg.write_flag = pick_reg_value();
         next_cfg.read_flag = pick_reg_value();
         next_cfg.node_mask = pick_reg_value();
         next_cfg.crc_poly = pick_reg_value();
         next_cfg.crc_init = pick_reg_value();
         next_cfg.crc_xorout = pick_reg_value();
         write_setting(next_cfg);
         if ($urandom_range(0, 2) == 0) write_csr(CSR_UNUSED_IDX, 8'($urandom_range(0, 255)));
         settings_used++;
         for (int i = 0; i < RAND_ITEMS_PER_PHASE; i++) begin
            if (i % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0) wait_idle();
            issue_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                          1'b0, 8'h00, 1'b0, 8'h00, pick_gap());
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Checked %0d words from %0d write and %0d read frames.",
               words_checked, write_frames, read_frames);
      $display("Register settings used: %0d, register writes: %0d, failures: %0d.",
               settings_used, csr_writes, failures);
      if (failures == 0 && frame_words.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
